// ----- design/cps_pkg.sv -----
package cps_pkg;

	// Vertex store size and derived index widths
	localparam int MAX_SIDES = 8;
	localparam int IDX_W     = $clog2(MAX_SIDES);
	localparam int CNT_W     = $clog2(MAX_SIDES + 1);

	// Field widths
	localparam int CW      = 20;  // coordinate
	localparam int RAD_W   = 19;  // radius
	localparam int DEPTH_W = 20;  // depth output
	localparam int NW      = 16;  // Q1.14 normal
	localparam int NFRAC   = 14;  // normal fraction bits

	// Datapath widths
	localparam int AW     = CW + 1;        // axis component, coordinate difference
	localparam int PRW    = 2 * AW;        // one product
	localparam int PW     = PRW + 1;       // sum of two products
	localparam int TW     = PW + 3;        // interval ends and depths
	localparam int SQ_W   = 60;            // root radicand, even width
	localparam int ROOT_W = SQ_W / 2;
	localparam int DVD_W  = AW + 22;       // |axis| * 2^22 plus rounding term
	localparam int QUO_W  = 16;            // quotient bits, the result stays below 2^15

	localparam logic REQ_QUERY = 1'b1;

	typedef struct packed {
		logic              req_type;
		logic [2:0]        vertex_slot;
		logic signed [19:0] vertex_xpos;
		logic signed [19:0] vertex_ypos;
		logic [3:0]        side_count;
		logic signed [19:0] ball_x;
		logic signed [19:0] ball_y;
		logic [18:0]       radius;
		logic signed [19:0] center_x;
		logic signed [19:0] center_y;
	} in_item_t;

	typedef struct packed {
		logic              hit;
		logic [19:0]       depth;
		logic signed [15:0] normal_x;
		logic signed [15:0] normal_y;
	} out_item_t;

	typedef enum logic [2:0] {
		MUL_NONE,
		MUL_SQR,
		MUL_PROJ,
		MUL_CIRC,
		MUL_DIST,
		MUL_ORIENT
	} mul_op_t;

	typedef struct packed {
		logic             wr_vert;
		logic             ld_query;
		logic             ld_vi;
		logic             ld_edge;
		logic             ld_near;
		mul_op_t          mul_op;
		logic             first;
		logic [IDX_W-1:0] idx;
		logic             div_go;
		logic             div_y;
		logic             test1;
		logic             test2;
		logic             take;
		logic             take_first;
		logic             out_ld;
		logic             out_hit;
	} cps_cmd_t;

	typedef struct packed {
		logic root_done;
		logic root_zero;
		logic div_done;
		logic sep;
	} cps_stat_t;

endpackage

// ----- design/cps_sqrt.sv -----
module cps_sqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [cps_pkg::SQ_W-1:0]   radicand,
	output logic                       done,
	output logic [cps_pkg::ROOT_W-1:0] root
);
	import cps_pkg::*;

	localparam int CNTW = $clog2(ROOT_W);

	logic            busy_q;
	logic            done_q;
	logic [CNTW-1:0] cnt_q;
	logic [SQ_W-1:0] v_q;
	logic [ROOT_W+1:0] rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [ROOT_W+2:0] r4;
	logic [ROOT_W+2:0] trial;
	logic              ge;

	// One result bit per step: bring down two radicand bits, try root*4+1
	always_comb begin
		r4    = {rem_q[ROOT_W:0], v_q[SQ_W-1 -: 2]};
		trial = {1'b0, root_q, 2'b01};
		ge    = (r4 >= trial);
	end

	// Step count and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(ROOT_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// Remainder and root
	always_ff @(posedge clk) begin
		if (start) begin
			v_q    <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			v_q <= v_q << 2;
			if (ge) begin
				rem_q  <= (ROOT_W+2)'(r4 - trial);
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= r4[ROOT_W+1:0];
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// ----- design/cps_div.sv -----
module cps_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [cps_pkg::DVD_W-1:0]  dividend,
	input  logic [cps_pkg::ROOT_W-1:0] divisor,
	output logic                       done,
	output logic [cps_pkg::QUO_W-1:0]  quo
);
	import cps_pkg::*;

	localparam int CNTW = $clog2(QUO_W);

	logic              busy_q;
	logic              done_q;
	logic [CNTW-1:0]   cnt_q;
	logic [ROOT_W-1:0] rem_q;
	logic [ROOT_W-1:0] dvs_q;
	logic [QUO_W-1:0]  q_q;
	logic [ROOT_W:0]   t;
	logic              ge;

	// Restoring division, one quotient bit per step
	always_comb begin
		t  = {rem_q, q_q[QUO_W-1]};
		ge = (t >= {1'b0, dvs_q});
	end

	// Step count and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(QUO_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// High dividend bits start below the divisor, low bits shift in
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= ROOT_W'(dividend[DVD_W-1:QUO_W]);
			q_q   <= dividend[QUO_W-1:0];
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? ROOT_W'(t - {1'b0, dvs_q}) : t[ROOT_W-1:0];
			q_q   <= {q_q[QUO_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = q_q;

endmodule

// ----- design/cps_dp.sv -----
module cps_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  cps_pkg::in_item_t  in_data,
	input  cps_pkg::cps_cmd_t  cmd,
	output cps_pkg::cps_stat_t stat,
	output cps_pkg::out_item_t out_data
);
	import cps_pkg::*;

	logic signed [CW-1:0]  vx_q [MAX_SIDES];
	logic signed [CW-1:0]  vy_q [MAX_SIDES];
	logic signed [CW-1:0]  bx_q, by_q, cx_q, cy_q, vix_q, viy_q;
	logic [RAD_W-1:0]      r_q;
	logic signed [AW-1:0]  ax_q, ay_q;
	logic signed [NW-1:0]  nx_q, ny_q, bnx_q, bny_q;
	logic signed [PRW-1:0] px_s1, py_s1;
	mul_op_t               op_s1;
	logic                  first_s1;
	logic [IDX_W-1:0]      idx_s1;
	logic signed [PW-1:0]  mina_q, maxa_q, c_q, bd_q;
	logic [IDX_W-1:0]      k_q;
	logic signed [TW-1:0]  minb_q, maxb_q, d_q, best_q;
	logic                  sep_q, flip_q, dsel_q, dneg_q;
	out_item_t             out_q;

	logic signed [AW-1:0]  ma_x, mb_x, ma_y, mb_y;
	logic signed [PW-1:0]  psum;
	logic signed [AW-1:0]  ex, ey, da;
	logic [AW-1:0]         dmag;
	logic [DVD_W-1:0]      dvd;
	logic signed [TW-1:0]  half, d1, d2;
	logic [TW-1:0]         bestr;
	logic [DEPTH_W-1:0]    depth_sat;
	logic                  root_done, div_done;
	logic [ROOT_W-1:0]     root;
	logic [QUO_W-1:0]      quo;
	logic signed [NW-1:0]  qs;

	// Select multiplier operands
	always_comb begin
		ma_x = '0;
		mb_x = '0;
		ma_y = '0;
		mb_y = '0;
		unique case (cmd.mul_op)
			MUL_SQR: begin
				ma_x = ax_q;
				mb_x = ax_q;
				ma_y = ay_q;
				mb_y = ay_q;
			end
			MUL_PROJ: begin
				ma_x = AW'(vx_q[cmd.idx]);
				mb_x = AW'(nx_q);
				ma_y = AW'(vy_q[cmd.idx]);
				mb_y = AW'(ny_q);
			end
			MUL_CIRC: begin
				ma_x = AW'(bx_q);
				mb_x = AW'(nx_q);
				ma_y = AW'(by_q);
				mb_y = AW'(ny_q);
			end
			MUL_DIST: begin
				ma_x = AW'(vx_q[cmd.idx]) - AW'(bx_q);
				mb_x = ma_x;
				ma_y = AW'(vy_q[cmd.idx]) - AW'(by_q);
				mb_y = ma_y;
			end
			MUL_ORIENT: begin
				ma_x = AW'(cx_q) - AW'(bx_q);
				mb_x = AW'(bnx_q);
				ma_y = AW'(cy_q) - AW'(by_q);
				mb_y = AW'(bny_q);
			end
			default: begin
			end
		endcase
	end

	// Edge, test and output arithmetic
	always_comb begin
		psum  = PW'(px_s1) + PW'(py_s1);
		ex    = AW'(vx_q[cmd.idx]) - AW'(vix_q);
		ey    = AW'(vy_q[cmd.idx]) - AW'(viy_q);
		da    = cmd.div_y ? ay_q : ax_q;
		dmag  = da[AW-1] ? AW'(-da) : da;
		dvd   = {dmag, 22'd0} + DVD_W'(root >> 1);
		half  = {{(TW-RAD_W-NFRAC){1'b0}}, r_q, {NFRAC{1'b0}}};
		d1    = maxb_q - TW'(mina_q);
		d2    = TW'(maxa_q) - minb_q;
		qs    = dneg_q ? -NW'(quo) : NW'(quo);
		bestr = TW'(best_q) + TW'(1 << (NFRAC - 1));
		if (bestr[TW-1:NFRAC+DEPTH_W] != '0)
			depth_sat = '1;
		else
			depth_sat = bestr[NFRAC+DEPTH_W-1:NFRAC];
	end

	// Root of the squared axis length, with 8 guard bits
	cps_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (op_s1 == MUL_SQR),
		.radicand ({1'b0, psum[PW-1:0], 16'd0}),
		.done     (root_done),
		.root     (root)
	);

	// Axis component over length, rounded
	cps_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_go),
		.dividend (dvd),
		.divisor  (root),
		.done     (div_done),
		.quo      (quo)
	);

	// Track which product op sits in the product stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= MUL_NONE;
		end else begin
			op_s1 <= cmd.mul_op;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.wr_vert && int'(in_data.vertex_slot) < MAX_SIDES) begin
			vx_q[IDX_W'(in_data.vertex_slot)] <= in_data.vertex_xpos;
			vy_q[IDX_W'(in_data.vertex_slot)] <= in_data.vertex_ypos;
		end
		if (cmd.ld_query) begin
			bx_q <= in_data.ball_x;
			by_q <= in_data.ball_y;
			cx_q <= in_data.center_x;
			cy_q <= in_data.center_y;
			r_q  <= in_data.radius;
		end
		if (cmd.ld_vi) begin
			vix_q <= vx_q[cmd.idx];
			viy_q <= vy_q[cmd.idx];
		end
		// Edge normal is (ey, -ex)
		if (cmd.ld_edge) begin
			ax_q <= ey;
			ay_q <= -ex;
		end
		if (cmd.ld_near) begin
			ax_q <= AW'(vx_q[k_q]) - AW'(bx_q);
			ay_q <= AW'(vy_q[k_q]) - AW'(by_q);
		end

		// Product stage
		px_s1    <= PRW'(ma_x) * PRW'(mb_x);
		py_s1    <= PRW'(ma_y) * PRW'(mb_y);
		first_s1 <= cmd.first;
		idx_s1   <= cmd.idx;

		// Consume the summed products
		unique case (op_s1)
			MUL_PROJ: begin
				if (first_s1 || psum < mina_q)
					mina_q <= psum;
				if (first_s1 || psum > maxa_q)
					maxa_q <= psum;
			end
			MUL_CIRC: c_q <= psum;
			MUL_DIST: begin
				if (first_s1 || psum < bd_q) begin
					bd_q <= psum;
					k_q  <= idx_s1;
				end
			end
			MUL_ORIENT: flip_q <= psum[PW-1];
			default: begin
			end
		endcase

		// Normal components from the divider
		if (cmd.div_go) begin
			dsel_q <= cmd.div_y;
			dneg_q <= da[AW-1];
		end
		if (div_done) begin
			if (dsel_q)
				ny_q <= qs;
			else
				nx_q <= qs;
		end

		// Circle interval, then gap and depth
		if (cmd.test1) begin
			minb_q <= TW'(c_q) - half;
			maxb_q <= TW'(c_q) + half;
		end
		if (cmd.test2) begin
			sep_q <= (TW'(mina_q) >= maxb_q) || (minb_q >= TW'(maxa_q));
			d_q   <= (d1 > d2) ? d2 : d1;
		end
		// Keep the shallowest axis, earlier one wins a tie
		if (cmd.take && (cmd.take_first || d_q < best_q)) begin
			best_q <= d_q;
			bnx_q  <= nx_q;
			bny_q  <= ny_q;
		end

		if (cmd.out_ld) begin
			if (cmd.out_hit) begin
				out_q.hit      <= 1'b1;
				out_q.depth    <= depth_sat;
				out_q.normal_x <= flip_q ? -bnx_q : bnx_q;
				out_q.normal_y <= flip_q ? -bny_q : bny_q;
			end else begin
				out_q <= '0;
			end
		end
	end

	always_comb begin
		stat.root_done = root_done;
		stat.root_zero = (root == '0);
		stat.div_done  = div_done;
		stat.sep       = sep_q;
	end

	assign out_data = out_q;

endmodule

// ----- design/cps_ctrl.sv -----
module cps_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               req_type,
	input  logic [3:0]         side_count,
	output logic               out_valid,
	input  logic               out_stall,
	input  cps_pkg::cps_stat_t stat,
	output cps_pkg::cps_cmd_t  cmd
);
	import cps_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_VI, S_EDGE, S_NEAR, S_SQR, S_ROOT, S_CHK,
		S_DIVX, S_DWX, S_DIVY, S_DWY, S_PROJ, S_CIRC, S_CW,
		S_T1, S_T2, S_DEC, S_DIST, S_DW, S_ORI, S_OW, S_FIN
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] n_q, i_q, p_q, n_d, j;
	logic             near_q, miss_q, out_valid_q, out_free;

	// Clamp side count into the supported range
	always_comb begin
		if (int'(side_count) < 3)
			n_d = CNT_W'(3);
		else if (int'(side_count) > MAX_SIDES)
			n_d = CNT_W'(MAX_SIDES);
		else
			n_d = CNT_W'(side_count);
		j        = (i_q + 1'b1 == n_q) ? '0 : i_q + 1'b1;
		out_free = !out_valid_q || !out_stall;
	end

	// Commands by state
	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.ld_query = (req_type == REQ_QUERY);
					cmd.wr_vert  = (req_type != REQ_QUERY);
				end
			end
			S_VI: begin
				cmd.ld_vi = 1'b1;
				cmd.idx   = i_q[IDX_W-1:0];
			end
			S_EDGE: begin
				cmd.ld_edge = 1'b1;
				cmd.idx     = j[IDX_W-1:0];
			end
			S_NEAR: cmd.ld_near = 1'b1;
			S_SQR:  cmd.mul_op  = MUL_SQR;
			S_DIVX: cmd.div_go  = 1'b1;
			S_DIVY: begin
				cmd.div_go = 1'b1;
				cmd.div_y  = 1'b1;
			end
			S_PROJ: begin
				cmd.mul_op = MUL_PROJ;
				cmd.idx    = p_q[IDX_W-1:0];
				cmd.first  = (p_q == '0);
			end
			S_CIRC: cmd.mul_op = MUL_CIRC;
			S_T1:   cmd.test1  = 1'b1;
			S_T2:   cmd.test2  = 1'b1;
			S_DEC: begin
				cmd.take       = !stat.sep;
				cmd.take_first = !near_q && (i_q == '0);
			end
			S_DIST: begin
				cmd.mul_op = MUL_DIST;
				cmd.idx    = p_q[IDX_W-1:0];
				cmd.first  = (p_q == '0);
			end
			S_ORI: cmd.mul_op = MUL_ORIENT;
			S_FIN: begin
				cmd.out_ld  = out_free;
				cmd.out_hit = !miss_q;
			end
			default: begin
			end
		endcase
	end

	// State, counters and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			n_q         <= '0;
			i_q         <= '0;
			p_q         <= '0;
			near_q      <= 1'b0;
			miss_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// Drop a taken result unless a new one replaces it
			if (out_valid_q && !out_stall && state_q != S_FIN)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && req_type == REQ_QUERY) begin
						n_q     <= n_d;
						i_q     <= '0;
						near_q  <= 1'b0;
						miss_q  <= 1'b0;
						state_q <= S_VI;
					end
				end
				S_VI:   state_q <= S_EDGE;
				S_EDGE: state_q <= S_SQR;
				S_NEAR: state_q <= S_SQR;
				S_SQR:  state_q <= S_ROOT;
				S_ROOT: begin
					if (stat.root_done)
						state_q <= S_CHK;
				end
				// A zero axis always separates
				S_CHK: begin
					if (stat.root_zero) begin
						miss_q  <= 1'b1;
						state_q <= S_FIN;
					end else begin
						state_q <= S_DIVX;
					end
				end
				S_DIVX: state_q <= S_DWX;
				S_DWX: begin
					if (stat.div_done)
						state_q <= S_DIVY;
				end
				S_DIVY: state_q <= S_DWY;
				S_DWY: begin
					if (stat.div_done) begin
						p_q     <= '0;
						state_q <= S_PROJ;
					end
				end
				S_PROJ: begin
					if (p_q + 1'b1 == n_q)
						state_q <= S_CIRC;
					else
						p_q <= p_q + 1'b1;
				end
				S_CIRC: state_q <= S_CW;
				S_CW:   state_q <= S_T1;
				S_T1:   state_q <= S_T2;
				S_T2:   state_q <= S_DEC;
				S_DEC: begin
					if (stat.sep) begin
						miss_q  <= 1'b1;
						state_q <= S_FIN;
					end else if (near_q) begin
						state_q <= S_ORI;
					end else if (i_q + 1'b1 == n_q) begin
						p_q     <= '0;
						state_q <= S_DIST;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= S_VI;
					end
				end
				S_DIST: begin
					if (p_q + 1'b1 == n_q)
						state_q <= S_DW;
					else
						p_q <= p_q + 1'b1;
				end
				S_DW: begin
					near_q  <= 1'b1;
					state_q <= S_NEAR;
				end
				S_ORI: state_q <= S_OW;
				S_OW:  state_q <= S_FIN;
				S_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

endmodule

// ----- design/circle_polygon_sat_test.sv -----
// Load item: written into its vertex slot, no result.
// Query: up to n + 1 axes, each worked through the 30-step root and two 16-step
// divides on one shared unit each, plus the vertex scan.
// A miss ends at the first separating axis. One item is worked on at a time.
// Reset clears control state; vertex slots hold nothing valid until written.
module circle_polygon_sat_test (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  cps_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output cps_pkg::out_item_t out_data
);
	import cps_pkg::*;

	cps_cmd_t  cmd;
	cps_stat_t stat;

	cps_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (in_data.req_type),
		.side_count (in_data.side_count),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.stat       (stat),
		.cmd        (cmd)
	);

	cps_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cmd      (cmd),
		.stat     (stat),
		.out_data (out_data)
	);

endmodule

// ----- design/cps_check.sv -----
module cps_check (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input cps_pkg::in_item_t  in_data,
	input logic               out_valid,
	input logic               out_stall,
	input cps_pkg::out_item_t out_data
);
	import cps_pkg::*;

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	// A miss carries no depth and no axis
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.hit |->
		out_data.depth == 0 && out_data.normal_x == 0 && out_data.normal_y == 0)
		else $error("miss with nonzero fields");

	// A query keeps the input side busy in the next cycle
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.req_type == REQ_QUERY |=> in_stall)
		else $error("query did not occupy the block");

	// A hit axis stays within unit length per component
	a_norm_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.hit |->
		out_data.normal_x >= -16384 && out_data.normal_x <= 16384 &&
		out_data.normal_y >= -16384 && out_data.normal_y <= 16384)
		else $error("normal out of range");

endmodule

bind circle_polygon_sat_test cps_check u_cps_check (.*);
